@@ sv/thsf_pkg.sv @@
// ----------------------------------------------------------------------------
// thsf_pkg
// Shared types and constants of the two-hit mismatch seed filter.
// ----------------------------------------------------------------------------
package thsf_pkg;

  localparam int unsigned LetterW   = 8;
  localparam int unsigned SeedCfgW  = 6;
  localparam int unsigned MisCfgW   = 6;
  localparam int unsigned WinCfgW   = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned SeenW     = 6;
  localparam int unsigned GapW      = 16;
  // effective seed length holds up to 64
  localparam int unsigned KeffW     = 7;

  localparam logic [SeenW-1:0]    SeenMax = '1;
  localparam logic [GapW-1:0]     GapMax  = '1;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgSeedLength    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxMismatches = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHitWindow     = 2'd2;

  localparam logic [SeedCfgW-1:0] SeedLengthRst    = 6'd12;
  localparam logic [MisCfgW-1:0]  MaxMismatchesRst = 6'd2;
  localparam logic [WinCfgW-1:0]  HitWindowRst     = 16'd40;

  // per-cycle control broadcast to every cell of the chain
  typedef struct packed {
    logic advance;
    logic clear;
  } cell_ctrl_t;

endpackage

@@ sv/thsf_cell.sv @@
// ----------------------------------------------------------------------------
// thsf_cell
// One position of the mismatch history: holds a bit, takes its neighbor's
// bit on every accepted item, drops it to zero on a clear and reports it when inside the seed window.
// ----------------------------------------------------------------------------
module thsf_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  thsf_pkg::cell_ctrl_t      ctrl_i,
  input  logic [thsf_pkg::KeffW-1:0] keff_i,
  input  logic                      bit_i,
  output logic                      bit_o,
  output logic                      win_bit_o
);

  logic bit_q, bit_d;
  logic shifted;

  assign shifted   = ctrl_i.advance ? bit_i : bit_q;
  // window covers positions 0 .. k-1 after the shift
  assign win_bit_o = shifted & (thsf_pkg::KeffW'(Idx) < keff_i);
  assign bit_d     = ctrl_i.clear ? 1'b0 : shifted;
  assign bit_o     = bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

endmodule

@@ sv/thsf_popcount.sv @@
// ----------------------------------------------------------------------------
// thsf_popcount
// Balanced adder tree counting the set bits of the window.
// ----------------------------------------------------------------------------
module thsf_popcount #(
  parameter int unsigned N = 32
) (
  input  logic [N-1:0]             bits_i,
  output logic [$clog2(N+1)-1:0]   count_o
);

  localparam int unsigned CW = $clog2(N + 1);
  localparam int unsigned LV = $clog2(N);
  localparam int unsigned P  = 1 << LV;

  logic [CW-1:0] node [2*P-1];

  for (genvar j = 0; j < P; j++) begin : g_leaf
    if (j < N) begin : g_bit
      assign node[P-1+j] = CW'(bits_i[j]);
    end else begin : g_pad
      assign node[P-1+j] = '0;
    end
  end

  for (genvar i = 0; i < P - 1; i++) begin : g_add
    assign node[i] = CW'(node[2*i+1] + node[2*i+2]);
  end

  assign count_o = node[0];

endmodule

@@ sv/two_hit_mismatch_seed_filter.sv @@
// ----------------------------------------------------------------------------
// two_hit_mismatch_seed_filter
// Counts mismatches over a sliding seed window along one diagonal and flags
// two seed matches that start within the hit window of each other.
// ----------------------------------------------------------------------------
//  channel | ports                                   | moves
//  --------+-----------------------------------------+--------------------------
//  in      | in_valid_i/in_ready_o, letters, last    | one letter pair per item
//  out     | out_valid_o/out_ready_i, two_hit_found  | one flag on the last item
//  cfg     | cfg_valid_i/cfg_ready_o, index, data    | one register write
//
//  One item per cycle while in_ready_o is high; a last item's flag shows in
//  the cycle after it is taken. Cell chain shift, popcount tree and gap
//  compare are combinational between the history cells and output register.
//  Reset clears the history and counters and loads the register defaults.
//  Input is taken while the output register is empty or being drained.
// ----------------------------------------------------------------------------
module two_hit_mismatch_seed_filter #(
  parameter int unsigned MAX_SEED = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [thsf_pkg::LetterW-1:0]    query_letter_i,
  input  logic [thsf_pkg::LetterW-1:0]    subject_letter_i,
  input  logic                            last_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            two_hit_found_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [thsf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [thsf_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_SEED + 1);

  logic [thsf_pkg::SeedCfgW-1:0] seed_length_q;
  logic [thsf_pkg::MisCfgW-1:0]  max_mismatches_q;
  logic [thsf_pkg::WinCfgW-1:0]  hit_window_q;

  logic [thsf_pkg::SeenW-1:0] seen_q, seen_d;
  logic [thsf_pkg::GapW-1:0]  gap_q, gap_d;
  logic                       match_q, match_d;
  logic                       hit_q, hit_d;
  logic                       out_valid_q, out_valid_d;
  logic                       found_q, found_d;

  logic                       accept;
  thsf_pkg::cell_ctrl_t       ctrl;
  logic [thsf_pkg::KeffW-1:0] keff;
  logic [MAX_SEED-1:0]        hist;
  logic [MAX_SEED-1:0]        win_bits;
  logic [CW-1:0]              mis_count;
  logic [thsf_pkg::SeenW-1:0] seen_inc;
  logic                       win_closed;
  logic                       is_match;
  logic [thsf_pkg::GapW-1:0]  gap_inc;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign ctrl.advance = accept;
  assign ctrl.clear   = accept && last_item_i;

  // clamp k into 1 .. MAX_SEED
  always_comb begin
    keff = thsf_pkg::KeffW'(seed_length_q);
    if (seed_length_q == '0) begin
      keff = thsf_pkg::KeffW'(1);
    end else if (keff > thsf_pkg::KeffW'(MAX_SEED)) begin
      keff = thsf_pkg::KeffW'(MAX_SEED);
    end
  end

  for (genvar i = 0; i < MAX_SEED; i++) begin : g_cell
    logic nb_in;
    if (i == 0) begin : g_head
      assign nb_in = (query_letter_i != subject_letter_i);
    end else begin : g_body
      assign nb_in = hist[i-1];
    end
    thsf_cell #(.Idx(i)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .keff_i    (keff),
      .bit_i     (nb_in),
      .bit_o     (hist[i]),
      .win_bit_o (win_bits[i])
    );
  end

  thsf_popcount #(.N(MAX_SEED)) u_popcount (
    .bits_i  (win_bits),
    .count_o (mis_count)
  );

  assign seen_inc   = (seen_q == thsf_pkg::SeenMax) ? seen_q : seen_q + 1'b1;
  assign win_closed = thsf_pkg::KeffW'(seen_inc) >= keff;
  assign is_match   = thsf_pkg::KeffW'(mis_count) <= thsf_pkg::KeffW'(max_mismatches_q);
  assign gap_inc    = (match_q && gap_q != thsf_pkg::GapMax) ? gap_q + 1'b1 : gap_q;

  always_comb begin
    seen_d      = seen_q;
    gap_d       = gap_q;
    match_d     = match_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && !out_ready_i;
    found_d     = found_q;
    if (accept) begin
      seen_d = seen_inc;
      if (win_closed) begin
        gap_d = gap_inc;
        if (is_match) begin
          if (match_q && gap_inc < hit_window_q) begin
            hit_d = 1'b1;
          end
          match_d = 1'b1;
          gap_d   = '0;
        end
      end
      if (last_item_i) begin
        out_valid_d = 1'b1;
        found_d     = hit_d;
        seen_d      = '0;
        gap_d       = '0;
        match_d     = 1'b0;
        hit_d       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      gap_q       <= '0;
      match_q     <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      seen_q      <= seen_d;
      gap_q       <= gap_d;
      match_q     <= match_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_length_q    <= thsf_pkg::SeedLengthRst;
      max_mismatches_q <= thsf_pkg::MaxMismatchesRst;
      hit_window_q     <= thsf_pkg::HitWindowRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        thsf_pkg::CfgSeedLength:
          seed_length_q <= cfg_data_i[thsf_pkg::SeedCfgW-1:0];
        thsf_pkg::CfgMaxMismatches:
          max_mismatches_q <= cfg_data_i[thsf_pkg::MisCfgW-1:0];
        thsf_pkg::CfgHitWindow:
          hit_window_q <= cfg_data_i[thsf_pkg::WinCfgW-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign two_hit_found_o = found_q;

endmodule

@@ verif/tb_two_hit_mismatch_seed_filter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_hit_mismatch_seed_filter
// Streams letter pairs of random diagonals through the seed filter across
// several window, mismatch and hit-window settings. A cycle-free model in the
// bench predicts the hit flag of every sequence. Both sides idle at random,
// and the receiver stalls long once while short diagonals pile up.
// ----------------------------------------------------------------------------
module tb_two_hit_mismatch_seed_filter;

  localparam int unsigned MaxSeed       = 32;
  localparam int unsigned LongHold      = 150;
  localparam int unsigned DrainPause    = 3;
  localparam int unsigned WatchdogLimit = 1000;
  // index past the last register; writes to it change nothing
  localparam logic [thsf_pkg::CfgIdxW-1:0] CfgSpare = 2'd3;

  typedef struct packed {
    logic [thsf_pkg::LetterW-1:0] query;
    logic [thsf_pkg::LetterW-1:0] subject;
    logic                         last;
  } letter_pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [thsf_pkg::LetterW-1:0]  query_letter = '0;
  logic [thsf_pkg::LetterW-1:0]  subject_letter = '0;
  logic                          last_item = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          two_hit_found;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [thsf_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [thsf_pkg::CfgDataW-1:0] cfg_data = '0;

  two_hit_mismatch_seed_filter #(
    .MAX_SEED(MaxSeed)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .query_letter_i  (query_letter),
    .subject_letter_i(subject_letter),
    .last_item_i     (last_item),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .two_hit_found_o (two_hit_found),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // handshakes seen at the last rising edge
  logic in_acc = 1'b0;
  logic out_acc = 1'b0;
  logic cfg_acc = 1'b0;

  letter_pair_t pending_pairs[$];
  logic         hit_flags_due[$];

  int unsigned pairs_queued = 0;
  int unsigned pairs_taken = 0;
  int unsigned sequences_done = 0;
  int unsigned hits_due = 0;
  int unsigned cfg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  int unsigned in_gap_max = 0;
  int unsigned out_gap_max = 0;
  int unsigned in_wait = 0;
  int unsigned out_hold = 0;
  int unsigned long_holds_asked = 0;
  int unsigned long_holds_taken = 0;

  // filter settings and diagonal state as the bench expects them
  logic [thsf_pkg::SeedCfgW-1:0] cfg_seed_len = thsf_pkg::SeedLengthRst;
  logic [thsf_pkg::MisCfgW-1:0]  cfg_mis_max = thsf_pkg::MaxMismatchesRst;
  logic [thsf_pkg::WinCfgW-1:0]  cfg_hit_win = thsf_pkg::HitWindowRst;
  logic [MaxSeed-1:0]            diag_mis_bits = '0;
  logic [thsf_pkg::SeenW-1:0]    diag_seen = '0;
  logic [thsf_pkg::GapW-1:0]     diag_gap = '0;
  logic                          diag_match = 1'b0;
  logic                          diag_hit = 1'b0;
  logic                          hit_want;

  function automatic int unsigned eff_seed(logic [thsf_pkg::SeedCfgW-1:0] s);
    if (s == 0) return 1;
    if (s > MaxSeed) return MaxSeed;
    return 32'(s);
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // advance the diagonal by one letter pair; queue the flag on a last item
  task automatic step_diagonal(letter_pair_t p);
    int unsigned k;
    int unsigned ones;
    k = eff_seed(cfg_seed_len);
    ones = 0;
    diag_mis_bits = {diag_mis_bits[MaxSeed-2:0], p.query != p.subject};
    if (diag_seen != thsf_pkg::SeenMax) diag_seen++;
    if (diag_seen >= k) begin
      for (int unsigned i = 0; i < k; i++) ones += 32'(diag_mis_bits[i]);
      if (diag_match && diag_gap != thsf_pkg::GapMax) diag_gap++;
      if (ones <= cfg_mis_max) begin
        if (diag_match && diag_gap < cfg_hit_win) diag_hit = 1'b1;
        diag_match = 1'b1;
        diag_gap = '0;
      end
    end
    if (p.last) begin
      hit_flags_due.push_back(diag_hit);
      sequences_done++;
      hits_due += 32'(diag_hit);
      diag_mis_bits = '0;
      diag_seen = '0;
      diag_gap = '0;
      diag_match = 1'b0;
      diag_hit = 1'b0;
    end
  endtask

  // sender: hold an item until taken, then wait its drawn gap
  always @(negedge clk_i) begin
    letter_pair_t p;
    if (rst_ni) begin
      if (in_valid && !in_acc) begin
        // hold
      end else if (in_wait > 0) begin
        in_valid <= 1'b0;
        in_wait <= in_wait - 1;
      end else if (pending_pairs.size() > 0) begin
        p = pending_pairs.pop_front();
        query_letter <= p.query;
        subject_letter <= p.subject;
        last_item <= p.last;
        in_valid <= 1'b1;
        in_wait <= $urandom_range(0, in_gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: after each result drop ready for a drawn gap, possibly none, or for a long stretch on request
  always @(negedge clk_i) begin
    int unsigned w;
    if (rst_ni) begin
      if (long_holds_taken != long_holds_asked) begin
        long_holds_taken <= long_holds_asked;
        out_hold <= LongHold;
        out_ready <= 1'b0;
      end else if (out_acc) begin
        w = $urandom_range(0, out_gap_max);
        out_hold <= w;
        out_ready <= (w == 0);
      end else if (out_hold > 0) begin
        out_hold <= out_hold - 1;
        out_ready <= (out_hold == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_acc <= in_valid && in_ready;
      out_acc <= out_valid && out_ready;
      cfg_acc <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          thsf_pkg::CfgSeedLength:    cfg_seed_len = cfg_data[thsf_pkg::SeedCfgW-1:0];
          thsf_pkg::CfgMaxMismatches: cfg_mis_max = cfg_data[thsf_pkg::MisCfgW-1:0];
          thsf_pkg::CfgHitWindow:     cfg_hit_win = cfg_data[thsf_pkg::WinCfgW-1:0];
          default: ;
        endcase
        cfg_writes++;
      end
      if (in_valid && in_ready) begin
        step_diagonal({query_letter, subject_letter, last_item});
        pairs_taken++;
      end
      if (out_valid && out_ready) begin
        if (hit_flags_due.size() == 0) begin
          report_mismatch($sformatf("hit flag %b with no sequence ended", two_hit_found));
        end else begin
          hit_want = hit_flags_due.pop_front();
          if (two_hit_found !== hit_want)
            report_mismatch($sformatf("two_hit_found %b, want %b", two_hit_found, hit_want));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no handshake for %0d cycles", WatchdogLimit);
        $display("tb_two_hit_mismatch_seed_filter NOT OK");
        $finish;
      end
    end
  end

  task automatic push_pair(logic [thsf_pkg::LetterW-1:0] q, logic [thsf_pkg::LetterW-1:0] s,
                           logic last);
    pending_pairs.push_back({q, s, last});
    pairs_queued++;
  endtask

  task automatic write_reg(logic [thsf_pkg::CfgIdxW-1:0] idx,
                           logic [thsf_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk_i); while (!cfg_acc);
    cfg_valid <= 1'b0;
  endtask

  // upper data bits of the narrow registers are junk and must be dropped
  task automatic set_filter(logic [thsf_pkg::SeedCfgW-1:0] seed,
                            logic [thsf_pkg::MisCfgW-1:0] mis,
                            logic [thsf_pkg::WinCfgW-1:0] win);
    write_reg(thsf_pkg::CfgSeedLength, {10'($urandom), seed});
    write_reg(thsf_pkg::CfgMaxMismatches, {10'($urandom), mis});
    write_reg(thsf_pkg::CfgHitWindow, win);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (pairs_taken != pairs_queued || hit_flags_due.size() != 0);
    repeat (DrainPause) @(negedge clk_i);
  endtask

  // whole diagonals, mostly near-matching, some pure noise
  task automatic run_diagonals(int unsigned target, int unsigned len_cap);
    int unsigned n;
    int unsigned len;
    int unsigned pct;
    logic [thsf_pkg::LetterW-1:0] q;
    n = 0;
    while (n < target) begin
      len = $urandom_range(1, len_cap);
      if (len_cap > 8 && $urandom_range(0, 7) == 0) len = $urandom_range(64, 90);
      case ($urandom_range(0, 4))
        0: pct = 0;
        1: pct = 4;
        2: pct = 12;
        3: pct = 40;
        default: pct = 100;
      endcase
      for (int unsigned i = 0; i < len; i++) begin
        q = 8'($urandom_range(0, 255));
        push_pair(q, ($urandom_range(0, 99) < pct) ? 8'($urandom_range(0, 255)) : q,
                  i == len - 1);
      end
      n += len;
    end
    wait_drained();
  endtask

  initial begin
    int unsigned ph;
    logic [thsf_pkg::SeedCfgW-1:0] seed;
    logic [thsf_pkg::MisCfgW-1:0] mis;
    logic [thsf_pkg::WinCfgW-1:0] win;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // defaults: too short, two close matches, too short and all mismatching
    push_pair(8'h00, 8'h00, 1'b1);
    for (int i = 0; i < 13; i++)
      push_pair(i[0] ? 8'hFF : 8'h00, i[0] ? 8'hFF : 8'h00, i == 12);
    for (int i = 0; i < 11; i++)
      push_pair(8'hAA, 8'h55, i == 10);
    wait_drained();
    run_diagonals(20, eff_seed(thsf_pkg::SeedLengthRst) + 24);

    for (ph = 1; ph <= 11; ph++) begin
      in_gap_max = (ph % 3 == 0) ? 0 : 11;
      out_gap_max = (ph % 4 == 1) ? 0 : 11;
      case (ph)
        1: begin seed = 0;  mis = 0;  win = 1;     end
        2: begin seed = 63; mis = 63; win = 0;     end
        3: begin seed = 33; mis = 0;  win = 16'hFFFF; end
        4: begin seed = 32; mis = 32; win = 2;     end
        5: begin seed = 1;  mis = 63; win = 3;     end
        default: begin
          seed = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(1, 16));
          mis = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 4));
          win = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(1, 60));
        end
      endcase
      set_filter(seed, mis, win);
      if (ph == 4) write_reg(CfgSpare, 16'($urandom));
      if (ph == 8) begin
        // stall the receiver while short diagonals pile up behind it
        in_gap_max = 0;
        long_holds_asked++;
        run_diagonals(45, 4);
      end else begin
        run_diagonals(20, eff_seed(seed) + 24);
      end
    end

    $display("ran %0d letter pairs in %0d diagonals through %0d register writes,",
             pairs_taken, sequences_done, cfg_writes);
    $display("  %0d of them flagged as two-hit, with random idling and one long stall",
             hits_due);
    if (mismatches == 0) begin
      $display("tb_two_hit_mismatch_seed_filter OK");
    end else begin
      $display("tb_two_hit_mismatch_seed_filter NOT OK");
    end
    $finish;
  end

endmodule

@@ two_hit_mismatch_seed_filter.f @@
sv/thsf_pkg.sv
sv/thsf_cell.sv
sv/thsf_popcount.sv
sv/two_hit_mismatch_seed_filter.sv
verif/tb_two_hit_mismatch_seed_filter.sv
